/* rtl/waypoint_bearing_and_range_defines.svh */
// assertion macros for the waypoint bearing and range block
// used by the checker; expects clk and rst_n in the scope of use
`ifndef WAYPOINT_BEARING_AND_RANGE_DEFINES_SVH
`define WAYPOINT_BEARING_AND_RANGE_DEFINES_SVH

// property checked on every clock edge outside reset
`define WBR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define WBR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/wbr_pkg.sv */
// shared widths, constants, control struct and arctangent table
// for the waypoint bearing and range pipeline; no dependencies
package wbr_pkg;

    // sizing
    localparam int COORD_BITS    = 13;
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int CORDIC_N      = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int ABS_BITS  = COORD_BITS;
    localparam int PRESCALE  = 20;
    localparam int CX_BITS   = ABS_BITS + PRESCALE + 4;

    // angle arithmetic, z in 1/65536 degree
    localparam int ANGLE_FRAC  = 16;
    localparam int Z_BITS      = ANGLE_FRAC + 9;
    localparam int ZMAX        = 90 << ANGLE_FRAC;
    localparam int ROUND_SHIFT = ANGLE_FRAC - 4;
    localparam int ROUND_HALF  = 1 << (ROUND_SHIFT - 1);
    localparam int P_BITS      = 11;

    // bearing in 1/16 degree
    localparam int BEARING_BITS = 13;
    localparam int B_BITS       = BEARING_BITS + 1;
    localparam int DEG90        = 1440;
    localparam int DEG270       = 4320;
    localparam int DEG360       = 5760;

    // distance and square root
    localparam int DIST_BITS = 14;
    localparam int DIST_MAX  = 16383;
    localparam int SQ_BITS   = 2 * ABS_BITS;
    localparam int SUM_BITS  = SQ_BITS + 1;
    localparam int ROOT_BITS = (SUM_BITS + 1) / 2;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS  = ROOT_BITS + 2;
    localparam int DSAT_BITS = (ROOT_BITS > DIST_BITS) ? ROOT_BITS : DIST_BITS;

    // latencies after the difference register
    localparam int CORDIC_LAT = CORDIC_N + 1;
    localparam int SQRT_LAT   = ROOT_BITS + 2;
    localparam int CORE_LAT   = (CORDIC_LAT > SQRT_LAT) ? CORDIC_LAT : SQRT_LAT;
    localparam int ITER_REGS  = CORE_LAT - 1;
    localparam int ROOT_REGS  = CORE_LAT - 2;

    // quadrant and degenerate-case flags carried beside the angle
    typedef struct packed {
        logic dx_pos;
        logic dy_pos;
        logic ax_zero;
        logic ay_zero;
    } ctl_t;

    // atan(2^-i) in 1/65536 degree, rounded to nearest
    function automatic logic [Z_BITS-1:0] atan_entry(input int idx);
        logic [Z_BITS-1:0] v;
        case (idx)
            0:       v = Z_BITS'(2949120);
            1:       v = Z_BITS'(1740967);
            2:       v = Z_BITS'(919879);
            3:       v = Z_BITS'(466945);
            4:       v = Z_BITS'(234379);
            5:       v = Z_BITS'(117304);
            6:       v = Z_BITS'(58666);
            7:       v = Z_BITS'(29335);
            8:       v = Z_BITS'(14668);
            9:       v = Z_BITS'(7334);
            10:      v = Z_BITS'(3667);
            11:      v = Z_BITS'(1833);
            12:      v = Z_BITS'(917);
            13:      v = Z_BITS'(458);
            14:      v = Z_BITS'(229);
            15:      v = Z_BITS'(115);
            16:      v = Z_BITS'(57);
            17:      v = Z_BITS'(29);
            18:      v = Z_BITS'(14);
            19:      v = Z_BITS'(7);
            20:      v = Z_BITS'(4);
            21:      v = Z_BITS'(2);
            22:      v = Z_BITS'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/waypoint_bearing_and_range.sv */
// top level: bearing and range from a position pair; joins the cordic and
// square-root pipelines in a registered output stage; depends on wbr_pkg and the wbr_* stages
//
//   channel | direction | handshake            | fields
//   pos     | in        | pos_valid, pos_stall | cur_x, cur_y, tgt_x, tgt_y
//   nav     | out       | nav_valid, nav_stall | bearing, distance
//
// one item per cycle while no held result stalls the pipeline; stages in order: difference stage,
// sixteen cordic rotation stages, rounding stage, output register; depth set by the cordic chain
// the square-root path (squares, sum, one root bit per stage) is padded to the same depth
// reset clears only the valid bits; payload registers come up undefined
// nav_stall with a result waiting freezes every stage and raises pos_stall in the same cycle
module waypoint_bearing_and_range (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    pos_valid,
    output logic                                    pos_stall,
    input  logic signed [wbr_pkg::COORD_BITS-1:0]   cur_x,
    input  logic signed [wbr_pkg::COORD_BITS-1:0]   cur_y,
    input  logic signed [wbr_pkg::COORD_BITS-1:0]   tgt_x,
    input  logic signed [wbr_pkg::COORD_BITS-1:0]   tgt_y,
    output logic                                    nav_valid,
    input  logic                                    nav_stall,
    output logic        [wbr_pkg::BEARING_BITS-1:0] bearing,
    output logic        [wbr_pkg::DIST_BITS-1:0]    distance
);

    logic                                adv;
    logic                                s0_valid;
    logic          [wbr_pkg::ABS_BITS-1:0] s0_ax;
    logic          [wbr_pkg::ABS_BITS-1:0] s0_ay;
    wbr_pkg::ctl_t                       s0_ctl;
    logic                                core_valid;
    wbr_pkg::ctl_t                       core_ctl;
    logic          [wbr_pkg::P_BITS-1:0] core_angle;
    logic          [wbr_pkg::ROOT_BITS-1:0] core_root;

    logic signed   [wbr_pkg::B_BITS-1:0] p_sel;
    logic signed   [wbr_pkg::B_BITS-1:0] base;
    logic signed   [wbr_pkg::B_BITS-1:0] raw;
    logic signed   [wbr_pkg::B_BITS-1:0] wrapped;
    logic          [wbr_pkg::BEARING_BITS-1:0] bearing_next;
    logic          [wbr_pkg::DSAT_BITS-1:0] root_w;
    logic          [wbr_pkg::DIST_BITS-1:0] distance_next;

    logic                                nav_valid_reg;
    logic          [wbr_pkg::BEARING_BITS-1:0] bearing_reg;
    logic          [wbr_pkg::DIST_BITS-1:0] distance_reg;

    // the whole pipeline moves unless a finished item is held
    assign adv       = !(nav_valid_reg && nav_stall);
    assign pos_stall = !adv;

    wbr_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .src_valid (pos_valid),
        .cur_x     (cur_x),
        .cur_y     (cur_y),
        .tgt_x     (tgt_x),
        .tgt_y     (tgt_y),
        .valid     (s0_valid),
        .ax        (s0_ax),
        .ay        (s0_ay),
        .ctl       (s0_ctl)
    );

    wbr_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .src_valid (s0_valid),
        .ax        (s0_ax),
        .ay        (s0_ay),
        .ctl       (s0_ctl),
        .valid     (core_valid),
        .ctl_out   (core_ctl),
        .angle     (core_angle)
    );

    wbr_isqrt u_isqrt (
        .clk  (clk),
        .adv  (adv),
        .ax   (s0_ax),
        .ay   (s0_ay),
        .root (core_root)
    );

    // bearing from quadrant base and angle, with axis cases and wrap
    always_comb
    begin
        if (core_ctl.ax_zero)
        begin
            p_sel = wbr_pkg::B_BITS'(wbr_pkg::DEG90);
        end
        else if (core_ctl.ay_zero)
        begin
            p_sel = '0;
        end
        else
        begin
            p_sel = signed'(wbr_pkg::B_BITS'(core_angle));
        end

        base = core_ctl.dx_pos ? wbr_pkg::B_BITS'(wbr_pkg::DEG90)
                               : wbr_pkg::B_BITS'(wbr_pkg::DEG270);
        raw  = (core_ctl.dx_pos == core_ctl.dy_pos) ? base - p_sel : base + p_sel;

        if (raw >= wbr_pkg::B_BITS'(wbr_pkg::DEG360))
        begin
            wrapped = raw - wbr_pkg::B_BITS'(wbr_pkg::DEG360);
        end
        else if (raw < 0)
        begin
            wrapped = raw + wbr_pkg::B_BITS'(wbr_pkg::DEG360);
        end
        else
        begin
            wrapped = raw;
        end

        // coincident points
        if (core_ctl.ax_zero && core_ctl.ay_zero)
        begin
            bearing_next = '0;
        end
        else
        begin
            bearing_next = wrapped[wbr_pkg::BEARING_BITS-1:0];
        end
    end

    // distance with saturation for wide coordinates
    assign root_w        = wbr_pkg::DSAT_BITS'(core_root);
    assign distance_next = (root_w > wbr_pkg::DSAT_BITS'(wbr_pkg::DIST_MAX))
                           ? wbr_pkg::DIST_BITS'(wbr_pkg::DIST_MAX)
                           : root_w[wbr_pkg::DIST_BITS-1:0];

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nav_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            nav_valid_reg <= core_valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bearing_reg  <= bearing_next;
            distance_reg <= distance_next;
        end
    end

    assign nav_valid = nav_valid_reg;
    assign bearing   = bearing_reg;
    assign distance  = distance_reg;

endmodule

/* rtl/wbr_prep.sv */
// first pipeline stage: coordinate differences, magnitudes and quadrant flags
// depends on wbr_pkg
module wbr_prep (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  logic                                  src_valid,
    input  logic signed [wbr_pkg::COORD_BITS-1:0] cur_x,
    input  logic signed [wbr_pkg::COORD_BITS-1:0] cur_y,
    input  logic signed [wbr_pkg::COORD_BITS-1:0] tgt_x,
    input  logic signed [wbr_pkg::COORD_BITS-1:0] tgt_y,
    output logic                                  valid,
    output logic        [wbr_pkg::ABS_BITS-1:0]   ax,
    output logic        [wbr_pkg::ABS_BITS-1:0]   ay,
    output wbr_pkg::ctl_t                         ctl
);

    logic signed [wbr_pkg::DIFF_BITS-1:0] dx;
    logic signed [wbr_pkg::DIFF_BITS-1:0] dy;
    logic        [wbr_pkg::ABS_BITS-1:0]  ax_next;
    logic        [wbr_pkg::ABS_BITS-1:0]  ay_next;
    wbr_pkg::ctl_t                        ctl_next;
    logic                                 valid_reg;
    logic        [wbr_pkg::ABS_BITS-1:0]  ax_reg;
    logic        [wbr_pkg::ABS_BITS-1:0]  ay_reg;
    wbr_pkg::ctl_t                        ctl_reg;

    // exact differences and their magnitudes
    assign dx = wbr_pkg::DIFF_BITS'(tgt_x) - wbr_pkg::DIFF_BITS'(cur_x);
    assign dy = wbr_pkg::DIFF_BITS'(tgt_y) - wbr_pkg::DIFF_BITS'(cur_y);
    assign ax_next = wbr_pkg::ABS_BITS'(dx[wbr_pkg::DIFF_BITS-1] ? -dx : dx);
    assign ay_next = wbr_pkg::ABS_BITS'(dy[wbr_pkg::DIFF_BITS-1] ? -dy : dy);

    // quadrant and zero flags
    always_comb
    begin
        ctl_next.ax_zero = (dx == '0);
        ctl_next.ay_zero = (dy == '0);
        ctl_next.dx_pos  = !dx[wbr_pkg::DIFF_BITS-1] && !ctl_next.ax_zero;
        ctl_next.dy_pos  = !dy[wbr_pkg::DIFF_BITS-1] && !ctl_next.ay_zero;
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= src_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg  <= ax_next;
            ay_reg  <= ay_next;
            ctl_reg <= ctl_next;
        end
    end

    assign valid = valid_reg;
    assign ax    = ax_reg;
    assign ay    = ay_reg;
    assign ctl   = ctl_reg;

endmodule

/* rtl/wbr_cordic.sv */
// vectoring cordic pipeline, one rotation per stage, then clamp and rounding
// to 1/16 degree; carries the valid bit and flags alongside; depends on wbr_pkg
module wbr_cordic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                src_valid,
    input  logic          [wbr_pkg::ABS_BITS-1:0] ax,
    input  logic          [wbr_pkg::ABS_BITS-1:0] ay,
    input  wbr_pkg::ctl_t                       ctl,
    output logic                                valid,
    output wbr_pkg::ctl_t                       ctl_out,
    output logic          [wbr_pkg::P_BITS-1:0] angle
);

    localparam int NREG = wbr_pkg::ITER_REGS;

    logic signed [wbr_pkg::CX_BITS-1:0] x_reg [NREG];
    logic signed [wbr_pkg::CX_BITS-1:0] y_reg [NREG];
    logic signed [wbr_pkg::Z_BITS-1:0]  z_reg [NREG];
    logic        [NREG:0]               valid_reg;
    wbr_pkg::ctl_t                      ctl_reg [NREG+1];
    logic        [wbr_pkg::P_BITS-1:0]  p_reg;

    logic signed [wbr_pkg::Z_BITS-1:0]  z_last;
    logic        [wbr_pkg::Z_BITS-1:0]  z_clamp;
    logic        [wbr_pkg::Z_BITS-1:0]  z_round;
    logic        [wbr_pkg::P_BITS-1:0]  p_next;

    // rotation stages; stages past the table length only carry the values
    for (genvar k = 0; k < NREG; k++)
    begin : g_stage
        logic signed [wbr_pkg::CX_BITS-1:0] xi;
        logic signed [wbr_pkg::CX_BITS-1:0] yi;
        logic signed [wbr_pkg::Z_BITS-1:0]  zi;
        logic signed [wbr_pkg::CX_BITS-1:0] x_next;
        logic signed [wbr_pkg::CX_BITS-1:0] y_next;
        logic signed [wbr_pkg::Z_BITS-1:0]  z_next;

        if (k == 0)
        begin : g_first
            assign xi = signed'(wbr_pkg::CX_BITS'({ax, {wbr_pkg::PRESCALE{1'b0}}}));
            assign yi = signed'(wbr_pkg::CX_BITS'({ay, {wbr_pkg::PRESCALE{1'b0}}}));
            assign zi = '0;
        end
        else
        begin : g_chain
            assign xi = x_reg[k-1];
            assign yi = y_reg[k-1];
            assign zi = z_reg[k-1];
        end

        if (k < wbr_pkg::CORDIC_N)
        begin : g_rot
            // drive y toward zero, accumulate the angle
            always_comb
            begin
                if (!yi[wbr_pkg::CX_BITS-1])
                begin
                    x_next = xi + (yi >>> k);
                    y_next = yi - (xi >>> k);
                    z_next = zi + signed'(wbr_pkg::atan_entry(k));
                end
                else
                begin
                    x_next = xi - (yi >>> k);
                    y_next = yi + (xi >>> k);
                    z_next = zi - signed'(wbr_pkg::atan_entry(k));
                end
            end
        end
        else
        begin : g_pass
            assign x_next = xi;
            assign y_next = yi;
            assign z_next = zi;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[k] <= x_next;
                y_reg[k] <= y_next;
                z_reg[k] <= z_next;
            end
        end
    end

    // clamp to 0..90 degrees and round half up to 1/16 degree
    assign z_last = z_reg[NREG-1];
    always_comb
    begin
        if (z_last < 0)
        begin
            z_clamp = '0;
        end
        else if (z_last > signed'(wbr_pkg::Z_BITS'(wbr_pkg::ZMAX)))
        begin
            z_clamp = wbr_pkg::Z_BITS'(wbr_pkg::ZMAX);
        end
        else
        begin
            z_clamp = unsigned'(z_last);
        end
        z_round = z_clamp + wbr_pkg::Z_BITS'(wbr_pkg::ROUND_HALF);
        p_next  = z_round[wbr_pkg::ROUND_SHIFT +: wbr_pkg::P_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg <= p_next;
        end
    end

    // valid bits travel with the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NREG-1:0], src_valid};
        end
    end

    // flags travel with the stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0] <= ctl;
            for (int i = 1; i <= NREG; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    assign valid   = valid_reg[NREG];
    assign ctl_out = ctl_reg[NREG];
    assign angle   = p_reg;

endmodule

/* rtl/wbr_isqrt.sv */
// distance pipeline: squares, sum, then one root bit per stage
// padded to the cordic latency; depends on wbr_pkg
module wbr_isqrt (
    input  logic                            clk,
    input  logic                            adv,
    input  logic [wbr_pkg::ABS_BITS-1:0]    ax,
    input  logic [wbr_pkg::ABS_BITS-1:0]    ay,
    output logic [wbr_pkg::ROOT_BITS-1:0]   root
);

    localparam int NREG = wbr_pkg::ROOT_REGS;

    logic [wbr_pkg::SQ_BITS-1:0]   sqx_reg;
    logic [wbr_pkg::SQ_BITS-1:0]   sqy_reg;
    logic [wbr_pkg::SUM_BITS-1:0]  sum_reg;
    logic [wbr_pkg::RAD_BITS-1:0]  rad_reg  [NREG];
    logic [wbr_pkg::REM_BITS-1:0]  rem_reg  [NREG];
    logic [wbr_pkg::ROOT_BITS-1:0] root_reg [NREG];

    // squares, then their sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg <= wbr_pkg::SQ_BITS'(ax) * wbr_pkg::SQ_BITS'(ax);
            sqy_reg <= wbr_pkg::SQ_BITS'(ay) * wbr_pkg::SQ_BITS'(ay);
            sum_reg <= wbr_pkg::SUM_BITS'(sqx_reg) + wbr_pkg::SUM_BITS'(sqy_reg);
        end
    end

    // digit-by-digit root, two radicand bits per stage
    for (genvar t = 0; t < NREG; t++)
    begin : g_stage
        logic [wbr_pkg::RAD_BITS-1:0]  rad_i;
        logic [wbr_pkg::REM_BITS-1:0]  rem_i;
        logic [wbr_pkg::ROOT_BITS-1:0] root_i;
        logic [wbr_pkg::RAD_BITS-1:0]  rad_next;
        logic [wbr_pkg::REM_BITS-1:0]  rem_next;
        logic [wbr_pkg::ROOT_BITS-1:0] root_next;

        if (t == 0)
        begin : g_first
            assign rad_i  = wbr_pkg::RAD_BITS'(sum_reg);
            assign rem_i  = '0;
            assign root_i = '0;
        end
        else
        begin : g_chain
            assign rad_i  = rad_reg[t-1];
            assign rem_i  = rem_reg[t-1];
            assign root_i = root_reg[t-1];
        end

        if (t < wbr_pkg::ROOT_BITS)
        begin : g_step
            logic [wbr_pkg::REM_BITS-1:0] rem_sh;
            logic [wbr_pkg::REM_BITS-1:0] trial;

            always_comb
            begin
                rem_sh   = {rem_i[wbr_pkg::REM_BITS-3:0], rad_i[wbr_pkg::RAD_BITS-1 -: 2]};
                trial    = {root_i, 2'b01};
                rad_next = {rad_i[wbr_pkg::RAD_BITS-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_i[wbr_pkg::ROOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_i[wbr_pkg::ROOT_BITS-2:0], 1'b0};
                end
            end
        end
        else
        begin : g_pass
            assign rad_next  = rad_i;
            assign rem_next  = rem_i;
            assign root_next = root_i;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg[t]  <= rad_next;
                rem_reg[t]  <= rem_next;
                root_reg[t] <= root_next;
            end
        end
    end

    assign root = root_reg[NREG-1];

endmodule

/* rtl/wbr_checker.sv */
// port-level checks for the waypoint bearing and range block, with its bind
// depends on wbr_pkg and waypoint_bearing_and_range_defines.svh
`include "waypoint_bearing_and_range_defines.svh"

module wbr_checker (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    pos_stall,
    input logic                                    nav_valid,
    input logic                                    nav_stall,
    input logic        [wbr_pkg::BEARING_BITS-1:0] bearing,
    input logic        [wbr_pkg::DIST_BITS-1:0]    distance
);

    // a held result stays put
    `WBR_ASSERT(a_hold, nav_valid && nav_stall |=> nav_valid && $stable(bearing) && $stable(distance), "result changed while stalled")

    // the input side only stalls behind a held result
    `WBR_ASSERT(a_stall_cause, pos_stall |-> nav_valid && nav_stall, "input stalled without a held result")

    // bearing stays below a full turn
    `WBR_ASSERT(a_bearing_range, nav_valid |-> bearing < wbr_pkg::BEARING_BITS'(wbr_pkg::DEG360), "bearing out of range")

    // a clock edge in reset leaves no result showing
    `WBR_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !nav_valid, "result valid during reset")

endmodule

bind waypoint_bearing_and_range wbr_checker u_checker (.*);
